// File: sv/imh_pkg.sv
package imh_pkg;
    localparam int HeapDepth = 1024;
    localparam int SlotW     = $clog2(HeapDepth);
    localparam int CntW      = SlotW + 1;
    localparam int KeyW      = 16;
    localparam int IdW       = 10;

    localparam logic       FuncPush = 1'b0;
    localparam logic       FuncPop  = 1'b1;
    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StEmpty  = 2'd1;
    localparam logic [1:0] StFull   = 2'd2;

    // heap slot entry as stored in memory
    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [KeyW-1:0] key;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LAST,
        S_POP_ROOT,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_FINAL,
        S_OUT
    } t_state;
endpackage

// File: sv/imh_ram.sv
// single port read, single port write heap storage, registered read
module imh_ram (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [imh_pkg::SlotW-1:0] i_waddr,
    input  imh_pkg::t_entry       i_wdata,
    input  logic [imh_pkg::SlotW-1:0] i_raddr,
    output imh_pkg::t_entry       o_rdata
);
    import imh_pkg::*;

    t_entry r_mem [HeapDepth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/indexed_min_heap.sv
// One item at a time: s_axis_tready is high only in idle, so a new item is
// accepted only once the last word of the previous one is in the output register.
// Each item yields up to log2(depth)+1 words; an error item yields a single word.
// A word waiting on the output stalls the item.
// Reset: synchronous active-low; clears the element count, control state and
// output valid; heap RAM contents are not cleared.
module indexed_min_heap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] cost_key, [25:16] item_id, zero pad
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [9:0] moved_id, [25:10] moved_key, [35:26] new_slot
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);
    import imh_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0]  r_count, n_count;
    logic [SlotW-1:0] r_i, n_i, r_j, n_j, r_last, n_last;
    t_entry           r_v, n_v, r_cl, n_cl;
    logic [1:0]       r_err, n_err;

    // output word register
    logic             r_ovalid, n_ovalid;
    t_entry           r_oent, n_oent;
    logic [SlotW-1:0] r_oslot, n_oslot;
    logic [1:0]       r_ostat, n_ostat;
    logic             r_olast, n_olast;

    // memory port
    logic             we;
    logic [SlotW-1:0] waddr, raddr;
    t_entry           wdata, rdata;

    imh_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    logic             out_free;
    logic [SlotW-1:0] parent;
    logic [SlotW-1:0] left_c;
    logic [SlotW-1:0] right_c;
    logic             rsel;
    t_entry           ch;
    logic [SlotW-1:0] cj;
    logic             cj_has_kid;
    logic             in_acc;

    assign out_free = !r_ovalid || m_axis_tready;
    assign parent   = (r_i - SlotW'(1)) >> 1;
    assign left_c   = {r_i[SlotW-2:0], 1'b1};   // 2*i+1, below last when used
    assign right_c  = r_j + SlotW'(1);
    // right child only if present and strictly smaller
    assign rsel     = (right_c < r_last) && (rdata.key < r_cl.key);
    assign ch       = rsel ? rdata : r_cl;
    assign cj       = rsel ? right_c : r_j;
    assign cj_has_kid = {1'b0, cj, 1'b1} < {2'b00, r_last};
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == FuncPush) begin
                        n_state = (r_count >= CntW'(HeapDepth)) ? S_OUT :
                                  (r_count == '0) ? S_FINAL : S_UP_RD;
                    end else begin
                        n_state = (r_count == '0) ? S_OUT : S_POP_RD;
                    end
                end
            end
            S_UP_RD:  n_state = S_UP_CMP;
            S_UP_CMP: begin
                if (!(rdata.key > r_v.key)) begin
                    n_state = S_FINAL;
                end else if (out_free) begin
                    n_state = (parent == '0) ? S_FINAL : S_UP_RD;
                end
            end
            S_POP_RD:   n_state = S_POP_LAST;
            S_POP_LAST: n_state = (r_last == '0) ? S_FINAL : S_POP_ROOT;
            S_POP_ROOT: if (out_free) begin
                n_state = (r_last > SlotW'(1)) ? S_DN_RD : S_FINAL;
            end
            S_DN_RD:  n_state = S_DN_RD2;
            S_DN_RD2: n_state = S_DN_CMP;
            S_DN_CMP: begin
                if (r_v.key <= ch.key) begin
                    n_state = S_FINAL;
                end else if (out_free) begin
                    n_state = cj_has_kid ? S_DN_RD : S_FINAL;
                end
            end
            S_FINAL: if (out_free) n_state = S_IDLE;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count = r_count; n_i = r_i; n_j = r_j; n_last = r_last;
        n_v = r_v; n_cl = r_cl; n_err = r_err;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_oent = r_oent; n_oslot = r_oslot; n_ostat = r_ostat; n_olast = r_olast;
        we = 1'b0; waddr = r_i; wdata = r_v; raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_v.key = s_axis_tdata[15:0];
                    n_v.id  = s_axis_tdata[25:16];
                    n_i     = r_count[SlotW-1:0];
                    n_err   = StOk;
                    if (s_axis_tuser == FuncPush) begin
                        if (r_count >= CntW'(HeapDepth)) n_err = StFull;
                        else n_count = r_count + CntW'(1);
                    end else if (r_count == '0) begin
                        n_err = StEmpty;
                    end else begin
                        n_last  = SlotW'(r_count - CntW'(1));
                        n_count = r_count - CntW'(1);
                    end
                end
            end
            S_UP_RD: raddr = parent;
            S_UP_CMP: begin
                // hold the parent read while the output is busy
                raddr = parent;
                if (out_free && rdata.key > r_v.key) begin
                    we = 1'b1; waddr = r_i; wdata = rdata;
                    n_ovalid = 1'b1; n_oent = rdata; n_oslot = r_i;
                    n_ostat = StOk; n_olast = 1'b0;
                    n_i = parent;
                end
            end
            S_POP_RD: raddr = r_last;   // last element
            S_POP_LAST: begin
                // last element arrives; fetch the root
                raddr = '0;
                n_v = rdata;
                n_i = '0;
            end
            S_POP_ROOT: begin
                // root goes to the old last slot
                raddr = '0;
                if (out_free) begin
                    we = 1'b1; waddr = r_last; wdata = rdata;
                    n_ovalid = 1'b1; n_oent = rdata; n_oslot = r_last;
                    n_ostat = StOk; n_olast = 1'b0;
                end
            end
            S_DN_RD: begin
                raddr = left_c;
                n_j = left_c;
            end
            S_DN_RD2: begin
                raddr = right_c;
                n_cl = rdata;
            end
            S_DN_CMP: begin
                raddr = right_c;
                if (out_free && !(r_v.key <= ch.key)) begin
                    we = 1'b1; waddr = r_i; wdata = ch;
                    n_ovalid = 1'b1; n_oent = ch; n_oslot = r_i;
                    n_ostat = StOk; n_olast = 1'b0;
                    n_i = cj;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    we = 1'b1; waddr = r_i; wdata = r_v;
                    n_ovalid = 1'b1; n_oent = r_v; n_oslot = r_i;
                    n_ostat = StOk; n_olast = 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_oent = '0; n_oslot = '0;
                    n_ostat = r_err; n_olast = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_i <= n_i; r_j <= n_j; r_last <= n_last; r_v <= n_v; r_cl <= n_cl;
        r_err <= n_err;
        r_oent <= n_oent; r_oslot <= n_oslot; r_ostat <= n_ostat; r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_oslot, r_oent.key, r_oent.id};
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;
endmodule

// File: sv/imh_checker.sv
module imh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import imh_pkg::*;

    // error words always close their run
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != StOk |-> m_axis_tlast)
        else $error("error word without last");

    // error words carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != StOk |-> m_axis_tdata == '0)
        else $error("error word with payload");

    // no new item taken in the cycle right after one was accepted
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back to back accept");

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
endmodule

bind indexed_min_heap imh_checker u_imh_checker (.*);

// File: tb/sv/indexed_min_heap_test.sv
module indexed_min_heap_test;
    timeunit 1ns;
    timeprecision 1ps;
    import imh_pkg::*;

    // heap result word as predicted
    typedef struct {
        logic [IdW-1:0]   id;
        logic [KeyW-1:0]  key;
        logic [SlotW-1:0] slot;
        logic [1:0]       st;
        logic             lst;
    } t_moved;

    // directed table row; chk_err marks a row whose sole result is an error word
    typedef struct {
        logic            func;
        logic [KeyW-1:0] key;
        logic [IdW-1:0]  id;
        logic            chk_err;
        logic [1:0]      err;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] cost_key, [25:16] item_id, zero pad
    logic        s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [9:0] moved_id, [25:10] moved_key, [35:26] new_slot
    logic [1:0]  m_axis_tuser;   // status
    logic        m_axis_tlast;

    indexed_min_heap uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic [KeyW-1:0] heap_key [HeapDepth];
    logic [IdW-1:0]  heap_id  [HeapDepth];
    int              heap_cnt;
    t_moved          moves_due[$];

    int  fail_cnt;
    int  cyc;
    int  hold_req;   // bumped by the sender to ask for a long receiver hold-off
    logic src_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > 400000) begin
                $display("indexed_min_heap: mismatch");
                $finish;
            end
        end
    end

    function automatic void note_move(logic [IdW-1:0] id, logic [KeyW-1:0] key,
                                      int slot, logic [1:0] st);
        t_moved m;
        m.id = id; m.key = key; m.slot = slot[SlotW-1:0]; m.st = st; m.lst = 1'b0;
        moves_due.push_back(m);
    endfunction

    // compute the moves one item causes and update the shadow heap
    function automatic void predict_heap(logic func, logic [KeyW-1:0] key,
                                         logic [IdW-1:0] id);
        int i, j, p, lastpos;
        logic [KeyW-1:0] vkey;
        logic [IdW-1:0]  vid;
        if (func == FuncPush) begin
            if (heap_cnt >= HeapDepth) begin
                note_move('0, '0, 0, StFull);
            end else begin
                i = heap_cnt;
                heap_cnt++;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (!(heap_key[p] > key)) break;
                    heap_key[i] = heap_key[p];
                    heap_id[i]  = heap_id[p];
                    note_move(heap_id[i], heap_key[i], i, StOk);
                    i = p;
                end
                heap_key[i] = key;
                heap_id[i]  = id;
                note_move(id, key, i, StOk);
            end
        end else if (heap_cnt == 0) begin
            note_move('0, '0, 0, StEmpty);
        end else begin
            lastpos  = heap_cnt - 1;
            heap_cnt = lastpos;
            if (lastpos == 0) begin
                note_move(heap_id[0], heap_key[0], 0, StOk);
            end else begin
                vkey = heap_key[lastpos];
                vid  = heap_id[lastpos];
                heap_key[lastpos] = heap_key[0];
                heap_id[lastpos]  = heap_id[0];
                note_move(heap_id[lastpos], heap_key[lastpos], lastpos, StOk);
                i = 0;
                j = 1;
                while (j < lastpos) begin
                    if (j + 1 < lastpos && heap_key[j+1] < heap_key[j]) j++;
                    if (vkey <= heap_key[j]) break;
                    heap_key[i] = heap_key[j];
                    heap_id[i]  = heap_id[j];
                    note_move(heap_id[i], heap_key[i], i, StOk);
                    i = j;
                    j = 2 * j + 1;
                end
                heap_key[i] = vkey;
                heap_id[i]  = vid;
                note_move(vid, vkey, i, StOk);
            end
        end
        moves_due[$].lst = 1'b1;
    endfunction

    // offer one word and wait for acceptance; valid stays up for a zero gap
    task automatic send_word(logic func, logic [KeyW-1:0] key, logic [IdW-1:0] id);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {6'd0, id, key};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_heap(func, key, id);
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (moves_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_row rows[$];
        t_row r;
        t_moved m;
        int n, k, mode;
        logic [KeyW-1:0] key;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FuncPush;
        heap_cnt = 0;
        fail_cnt = 0;
        hold_req = 0;
        src_done = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, single pop, extremes, ties, sift both ways
        rows.push_back('{FuncPop,  16'h0000, 10'h000, 1'b1, StEmpty});
        rows.push_back('{FuncPush, 16'h1234, 10'h3FF, 1'b0, StOk});
        rows.push_back('{FuncPop,  16'hFFFF, 10'h155, 1'b0, StOk});
        rows.push_back('{FuncPop,  16'h0000, 10'h000, 1'b1, StEmpty});
        rows.push_back('{FuncPush, 16'hFFFF, 10'h3FF, 1'b0, StOk});
        rows.push_back('{FuncPush, 16'h0000, 10'h000, 1'b0, StOk});
        rows.push_back('{FuncPush, 16'h8000, 10'h200, 1'b0, StOk});
        rows.push_back('{FuncPush, 16'h8000, 10'h201, 1'b0, StOk});
        rows.push_back('{FuncPush, 16'h0000, 10'h001, 1'b0, StOk});
        rows.push_back('{FuncPush, 16'h7FFF, 10'h2AA, 1'b0, StOk});
        rows.push_back('{FuncPush, 16'h5555, 10'h155, 1'b0, StOk});
        rows.push_back('{FuncPush, 16'hAAAA, 10'h0FF, 1'b0, StOk});
        for (k = 0; k < 8; k++)
            rows.push_back('{FuncPop, 16'hFFFF, 10'h3FF, 1'b0, StOk});
        rows.push_back('{FuncPop,  16'h0000, 10'h000, 1'b1, StEmpty});
        foreach (rows[x]) begin
            r = rows[x];
            send_word(r.func, r.key, r.id);
            // error rows: the predicted word must carry the row's status and zero payload
            if (r.chk_err) begin
                m = moves_due[$];
                if (m.st !== r.err || m.id !== '0 || m.key !== '0 || m.slot !== '0) begin
                    $error("status: expected %0d actual %0d", r.err, m.st);
                    fail_cnt++;
                end
            end
        end

        // random: push-biased then pop-biased, one long hold-off, one full drain
        for (n = 0; n < 160; n++) begin
            mode = $urandom_range(0, 9);
            key = (mode == 0) ? 16'hFFFF : (mode == 1) ? 16'h0000 :
                  (mode < 5) ? KeyW'($urandom_range(0, 15)) : KeyW'($urandom);
            if (n == 50) hold_req++;
            if (n == 110) drain_wait();
            if (n < 90 ? $urandom_range(0, 9) < 7 : $urandom_range(0, 9) < 4)
                send_word(FuncPush, key, IdW'($urandom));
            else
                send_word(FuncPop, KeyW'($urandom), IdW'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        src_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        int hold_done;
        hold_done = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_moved m;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (moves_due.size() == 0) begin
                $error("unexpected word: tdata %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                m = moves_due.pop_front();
                if (m_axis_tdata[9:0] !== m.id) begin
                    $error("moved_id: expected %0d actual %0d", m.id, m_axis_tdata[9:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[25:10] !== m.key) begin
                    $error("moved_key: expected %0d actual %0d", m.key, m_axis_tdata[25:10]);
                    fail_cnt++;
                end
                if (m_axis_tdata[35:26] !== m.slot) begin
                    $error("new_slot: expected %0d actual %0d", m.slot, m_axis_tdata[35:26]);
                    fail_cnt++;
                end
                if (m_axis_tuser !== m.st) begin
                    $error("status: expected %0d actual %0d", m.st, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tlast !== m.lst) begin
                    $error("last: expected %0d actual %0d", m.lst, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // end of run
    initial begin
        wait (src_done);
        while (moves_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && moves_due.size() == 0) begin
            $display("indexed_min_heap: match");
        end else begin
            $display("indexed_min_heap: mismatch");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/imh_pkg.sv
sv/imh_ram.sv
sv/indexed_min_heap.sv
sv/imh_checker.sv
tb/sv/indexed_min_heap_test.sv
